>>> hw/rtl/dtti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtti_pkg;

    // default magnitude width
    localparam int VALUE_WIDTH = 64;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SYNTAX = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_SIGNED_MODE = 2'd0;
    localparam logic [1:0] REG_LOWER_LIMIT = 2'd1;
    localparam logic [1:0] REG_UPPER_LIMIT = 2'd2;
    localparam logic [1:0] REG_FALLBACK    = 2'd3;

    // register reset values
    localparam logic [63:0] LOWER_LIMIT_RESET = 64'h8000_0000_0000_0000;
    localparam logic [63:0] UPPER_LIMIT_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FALLBACK_RESET    = 64'h0;

    // characters of interest
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

endpackage

`default_nettype wire

>>> hw/rtl/decimal_text_to_integer_checked.sv
`timescale 1ns / 1ps
`default_nettype none

// decimal text to integer converter with range and syntax checking
// throughput: one text byte per cycle unless the zero byte waits on a stalled result,
//   set by the single digit update (x10, add, compare); a byte is captured in the input
//   register and processed from there, and the zero byte then loads the result register
// reset: synchronous, active low; clears the parse state and returns the
//   registers to signed mode, full signed limits and a zero fallback

module decimal_text_to_integer_checked #(
    parameter int VALUE_WIDTH = dtti_pkg::VALUE_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // text byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_number_bits,
    output logic [1:0]       o_status,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int W = VALUE_WIDTH;

    // parse phases
    localparam logic [1:0] PH_SPACE  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_JUNK   = 2'd3;

    localparam logic [W-1:0] HALF_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MASK_VAL = {W{1'b1}};

    // configuration registers
    logic        r_signed_mode;
    logic [63:0] r_lower_limit;
    logic [63:0] r_upper_limit;
    logic [63:0] r_fallback;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parse state
    logic [1:0]   r_phase,     n_phase;
    logic         r_neg,       n_neg;
    logic [W-1:0] r_mag,       n_mag;
    logic         r_ovf,       n_ovf;
    logic         r_saw_digit, n_saw_digit;
    logic         r_junk,      n_junk;
    logic         r_refused,   n_refused;

    // result register
    logic         r_out_valid;
    logic [63:0]  r_number_bits, n_number_bits;
    logic [1:0]   r_status,      n_status;

    logic         w_zero;
    logic         w_fire;
    logic         w_take;
    logic         w_cfg_wr;

    // apb: always ready, register index in paddr[4:3]
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[4:3])
            dtti_pkg::REG_SIGNED_MODE: prdata = {63'd0, r_signed_mode};
            dtti_pkg::REG_LOWER_LIMIT: prdata = r_lower_limit;
            dtti_pkg::REG_UPPER_LIMIT: prdata = r_upper_limit;
            dtti_pkg::REG_FALLBACK:    prdata = r_fallback;
            default:                   prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_lower_limit <= dtti_pkg::LOWER_LIMIT_RESET;
            r_upper_limit <= dtti_pkg::UPPER_LIMIT_RESET;
            r_fallback    <= dtti_pkg::FALLBACK_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[4:3])
                dtti_pkg::REG_SIGNED_MODE: r_signed_mode <= pwdata[0];
                dtti_pkg::REG_LOWER_LIMIT: r_lower_limit <= pwdata;
                dtti_pkg::REG_UPPER_LIMIT: r_upper_limit <= pwdata;
                dtti_pkg::REG_FALLBACK:    r_fallback    <= pwdata;
                default: ;
            endcase
        end
    end

    // flow control: a non-zero byte always moves on, the zero byte waits
    // only while the result register still holds an untaken word
    assign w_zero     = (r_in_byte == dtti_pkg::CHAR_NUL);
    assign w_fire     = r_in_valid && (!w_zero || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_text_byte;
        end
    end

    // per-byte parse step and end-of-string result
    logic         w_digit;
    logic         w_space;
    logic [3:0]   w_dval;
    logic [W-1:0] w_lim;
    logic [W+3:0] w_next_mag;
    logic         w_digit_ovf;
    logic [W-1:0] w_value;
    logic [63:0]  w_value64;
    logic [1:0]   w_status;

    always_comb begin
        w_digit = (r_in_byte >= dtti_pkg::CHAR_ZERO) && (r_in_byte <= dtti_pkg::CHAR_NINE);
        w_space = r_in_byte inside {dtti_pkg::CHAR_SPACE,
                                    [dtti_pkg::CHAR_TAB:dtti_pkg::CHAR_CR]};
        w_dval  = r_in_byte[3:0];

        // magnitude limit for the current mode and sign
        if (!r_signed_mode) begin
            w_lim = MASK_VAL;
        end else if (r_neg) begin
            w_lim = HALF_VAL;
        end else begin
            w_lim = HALF_VAL - W'(1);
        end

        // mag*10 + d as shifts and adds, four guard bits catch the carry out
        w_next_mag  = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + (W+4)'(w_dval);
        w_digit_ovf = (w_next_mag > {4'd0, w_lim});

        n_phase     = r_phase;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ovf       = r_ovf;
        n_saw_digit = r_saw_digit;
        n_junk      = r_junk;
        n_refused   = r_refused;

        case (r_phase)
            PH_SPACE: begin
                if (w_space) begin
                    n_phase = PH_SPACE;
                end else if (r_in_byte == dtti_pkg::CHAR_PLUS) begin
                    n_phase = PH_SIGN;
                end else if (r_in_byte == dtti_pkg::CHAR_MINUS) begin
                    // a minus in unsigned mode is remembered as a range error
                    if (r_signed_mode) begin
                        n_neg = 1'b1;
                    end else begin
                        n_refused = 1'b1;
                    end
                    n_phase = PH_SIGN;
                end else if (w_digit) begin
                    n_saw_digit = 1'b1;
                    if (!r_ovf) begin
                        if (w_digit_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_mag = w_next_mag[W-1:0];
                        end
                    end
                    n_phase = PH_DIGITS;
                end else begin
                    n_junk  = 1'b1;
                    n_phase = PH_JUNK;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (w_digit) begin
                    n_saw_digit = 1'b1;
                    // magnitude freezes once overflowed
                    if (!r_ovf) begin
                        if (w_digit_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_mag = w_next_mag[W-1:0];
                        end
                    end
                    n_phase = PH_DIGITS;
                end else begin
                    n_junk  = 1'b1;
                    n_phase = PH_JUNK;
                end
            end
            default: begin
                n_junk  = 1'b1;
                n_phase = PH_JUNK;
            end
        endcase

        // final value: negate when signed and negative, then widen to 64 bits
        w_value = (r_signed_mode && r_neg) ? (W'(0) - r_mag) : r_mag;
        if (r_signed_mode) begin
            w_value64 = 64'($signed(w_value));
        end else begin
            w_value64 = 64'(w_value);
        end

        // error priority: refused minus, overflow, no digits, junk, limits
        if (r_refused || r_ovf) begin
            w_status = dtti_pkg::STATUS_RANGE;
        end else if (!r_saw_digit || r_junk) begin
            w_status = dtti_pkg::STATUS_SYNTAX;
        end else if (r_signed_mode) begin
            if (($signed(w_value64) < $signed(r_lower_limit)) ||
                ($signed(w_value64) > $signed(r_upper_limit))) begin
                w_status = dtti_pkg::STATUS_RANGE;
            end else begin
                w_status = dtti_pkg::STATUS_OK;
            end
        end else if (w_value64 > r_upper_limit) begin
            w_status = dtti_pkg::STATUS_RANGE;
        end else begin
            w_status = dtti_pkg::STATUS_OK;
        end

        n_status      = w_status;
        n_number_bits = (w_status == dtti_pkg::STATUS_OK) ? w_value64 : r_fallback;

        // the zero byte ends the string and clears the parse state
        if (w_zero) begin
            n_phase     = PH_SPACE;
            n_neg       = 1'b0;
            n_mag       = '0;
            n_ovf       = 1'b0;
            n_saw_digit = 1'b0;
            n_junk      = 1'b0;
            n_refused   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_ovf       <= 1'b0;
            r_saw_digit <= 1'b0;
            r_junk      <= 1'b0;
            r_refused   <= 1'b0;
        end else if (w_fire) begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_ovf       <= n_ovf;
            r_saw_digit <= n_saw_digit;
            r_junk      <= n_junk;
            r_refused   <= n_refused;
        end
    end

    // result register: loaded by the zero byte, held while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_zero) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_zero) begin
            r_number_bits <= n_number_bits;
            r_status      <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_number_bits = r_number_bits;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_ovf_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_saw_digit)
        else $error("overflow flagged without a digit");

    a_space_phase_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SPACE) |-> (!r_neg && !r_refused && !r_saw_digit && !r_junk && !r_ovf))
        else $error("parse flags set in leading space phase");

    a_junk_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_junk |-> (r_phase == PH_JUNK))
        else $error("junk flag outside junk phase");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_zero && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked end of string");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status != 2'd3))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
